// ----- design/hmg_pkg.sv -----
// ----------------------------------------------------------------------------
// Heightmap mesh generator package
// Shared types, widths and codes for the heightmap mesh generator.
// ----------------------------------------------------------------------------
package hmg_pkg;

    localparam int DEF_MAX_VERTS = 4096;
    localparam int DEF_MAX_DIM   = 64;

    localparam int DIM_W      = 7;
    localparam int IDX_W      = 12;
    localparam int ADDR_W     = 13;
    localparam int H_W        = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;
    localparam logic [H_W-1:0]   H_SAT     = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd1;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_CELL = 1'b1;

    localparam int DIV_NUM_W = 44;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = 6;

    localparam logic [DIV_CNT_W-1:0] LOAD_STEPS = 6'd24;
    localparam logic [DIV_CNT_W-1:0] ROW_STEPS  = 6'd12;
    localparam logic [DIV_CNT_W-1:0] FRAC_STEPS = 6'd24;
    localparam logic [DIV_CNT_W-1:0] NRM_STEPS  = 6'd44;

    localparam int SQ_VAL_W  = 64;
    localparam int SQ_ROOT_W = 32;
    localparam int SQ_CNT_W  = 6;

    localparam int NRM_W = 41;
    localparam int MAG_W = 40;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_ABS,
        ST_SHIFT,
        ST_ACC,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_WRITE,
        ST_EMIT
    } state_t;

    typedef enum logic [4:0] {
        OP_LOAD,
        OP_RG,
        OP_ROW,
        OP_FX0,
        OP_FZ0,
        OP_FX1,
        OP_FZ1,
        OP_HLL,
        OP_HTL,
        OP_HTR,
        OP_HLR,
        OP_N0,
        OP_N1,
        OP_N2,
        OP_S0,
        OP_S1,
        OP_S2,
        OP_Q0,
        OP_Q1,
        OP_Q2
    } op_t;

    typedef enum logic [2:0] {
        V_LL0,
        V_TL,
        V_TR0,
        V_LL1,
        V_TR1,
        V_LR
    } vert_t;

    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] item_index;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        pos_x;
        logic [15:0]        pos_height;
        logic [15:0]        pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic               last;
    } out_item_t;

endpackage

// ----- design/heightmap_mesh_generator_unit.sv -----
// ----------------------------------------------------------------------------
// Heightmap mesh generator
// Stores per-vertex heights from RGB pixels and emits the six vertices of a
// grid cell with positions and the unit face normal.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, in_data) carries load and cell
// requests; a transfer takes place when in_valid is high and in_stall is low.
// A load stores one vertex height and gives no output. A cell request inside
// the grid gives six transfers on the output channel (out_valid, out_stall,
// out_data), the sixth marked by last; a cell outside the grid gives none.
// The block takes one request at a time and raises in_stall while it works.
// A load with blue zero skips the division. A cell in the last row or column
// skips the far positions and the normal, and an inner cell whose normal is
// zero skips the square root and the normal division.
// The shared divider produces one quotient bit per cycle for the grid
// position, the four positions, the height and the three normal components,
// and the square root unit produces one root bit per cycle.
// When the receiver stalls, the current output is held and the block waits.
// The last output of a cell may still wait while the next request is taken.
// Reset returns grid_cols and grid_rows to 64 and clears the sequencer; the
// height store is not cleared, and a vertex must be loaded before it is read.
// ----------------------------------------------------------------------------
module heightmap_mesh_generator_unit #(
    parameter int MAX_VERTS = hmg_pkg::DEF_MAX_VERTS,
    parameter int MAX_DIM   = hmg_pkg::DEF_MAX_DIM
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [hmg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hmg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  hmg_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output hmg_pkg::out_item_t            out_data
);

    localparam int DW = hmg_pkg::DIM_W;
    localparam int MW = hmg_pkg::MAG_W;
    localparam int NW = hmg_pkg::NRM_W;

    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
        logic [DW-1:0] r;
        r = v;
        if (v < DW'(2))
        begin
            r = DW'(2);
        end
        else if (32'(v) > MAX_DIM)
        begin
            r = DW'(MAX_DIM);
        end
        return r;
    endfunction

    hmg_pkg::state_t  state_reg, state_next;
    hmg_pkg::op_t     op_reg, op_next;
    hmg_pkg::vert_t   emit_reg;
    logic [DW-1:0]    cols_reg, rows_reg;
    logic             out_valid_reg;
    hmg_pkg::out_item_t out_reg, out_next;

    logic [hmg_pkg::IDX_W-1:0] idx_reg;
    logic [7:0]                red_reg, green_reg, blue_reg;
    logic [15:0]               rg_reg;
    logic [hmg_pkg::H_W-1:0]   hgt_reg;
    logic [hmg_pkg::IDX_W-1:0] row_reg;
    logic [DW-1:0]             col_reg;
    logic [15:0]               fx0_reg, fx1_reg, fz0_reg, fz1_reg;
    logic signed [16:0]        bx_reg, az_reg;
    logic [hmg_pkg::H_W-1:0]   hll_reg, htl_reg, htr_reg, hlr_reg;
    logic signed [24:0]        nay_reg, dab_reg;
    logic signed [NW-1:0]      n_reg [3];
    logic [MW-1:0]             mag_reg [3];
    logic                      sgn_reg [3];
    logic [59:0]               sq_reg;
    logic [61:0]               sum_reg;
    logic signed [15:0]        q_reg [3];

    logic                      div_start, sqrt_start, mem_we, out_load;
    logic [hmg_pkg::DIV_NUM_W-1:0] div_num, div_quot;
    logic [hmg_pkg::DIV_DEN_W-1:0] div_den, div_rem;
    logic [hmg_pkg::DIV_CNT_W-1:0] div_steps;
    logic                      div_done, sqrt_done;
    logic [hmg_pkg::SQ_ROOT_W-1:0] sqrt_root;
    logic signed [31:0]        mul_a, mul_b;
    logic signed [63:0]        mul_p;
    logic [hmg_pkg::ADDR_W-1:0] rd_addr;
    logic [hmg_pkg::H_W-1:0]   rd_data;
    logic                      border;
    logic                      too_big;
    logic [15:0]               qmag;
    logic signed [16:0]        hdiff;

    assign border  = (col_reg == cols_reg - DW'(1)) ||
                     (row_reg == hmg_pkg::IDX_W'(rows_reg - DW'(1)));
    assign too_big = |(mag_reg[0][MW-1:30] | mag_reg[1][MW-1:30] | mag_reg[2][MW-1:30]);
    assign mul_p   = mul_a * mul_b;
    assign qmag    = div_quot[15:0];

    hmg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .steps (div_steps),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    hmg_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value ({2'b00, sum_reg}),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    hmg_store #(
        .DEPTH (MAX_VERTS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (hmg_pkg::ADDR_W'(idx_reg)),
        .wdata (hgt_reg),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            hmg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.req_type == hmg_pkg::REQ_LOAD)
                    begin
                        if (in_data.blue == 8'd0)
                        begin
                            state_next = hmg_pkg::ST_WRITE;
                        end
                        else
                        begin
                            state_next = hmg_pkg::ST_MUL;
                            op_next    = hmg_pkg::OP_RG;
                        end
                    end
                    else
                    begin
                        state_next = hmg_pkg::ST_DIV_GO;
                        op_next    = hmg_pkg::OP_ROW;
                    end
                end
            end
            hmg_pkg::ST_MUL:
            begin
                case (op_reg)
                    hmg_pkg::OP_RG:
                    begin
                        state_next = hmg_pkg::ST_DIV_GO;
                        op_next    = hmg_pkg::OP_LOAD;
                    end
                    hmg_pkg::OP_N0: op_next = hmg_pkg::OP_N1;
                    hmg_pkg::OP_N1: op_next = hmg_pkg::OP_N2;
                    hmg_pkg::OP_N2: state_next = hmg_pkg::ST_ABS;
                    hmg_pkg::OP_S0: op_next = hmg_pkg::OP_S1;
                    hmg_pkg::OP_S1: op_next = hmg_pkg::OP_S2;
                    default:        state_next = hmg_pkg::ST_ACC;
                endcase
            end
            hmg_pkg::ST_DIV_GO:
            begin
                state_next = hmg_pkg::ST_DIV_WAIT;
            end
            hmg_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = hmg_pkg::ST_DIV_GO;
                    case (op_reg)
                        hmg_pkg::OP_LOAD: state_next = hmg_pkg::ST_WRITE;
                        hmg_pkg::OP_ROW:
                        begin
                            if (div_quot[hmg_pkg::IDX_W-1:0] >=
                                hmg_pkg::IDX_W'(rows_reg))
                            begin
                                state_next = hmg_pkg::ST_IDLE;
                            end
                            else
                            begin
                                op_next = hmg_pkg::OP_FX0;
                            end
                        end
                        hmg_pkg::OP_FX0: op_next = hmg_pkg::OP_FZ0;
                        hmg_pkg::OP_FZ0:
                        begin
                            if (border)
                            begin
                                state_next = hmg_pkg::ST_RD_ADDR;
                                op_next    = hmg_pkg::OP_HLL;
                            end
                            else
                            begin
                                op_next = hmg_pkg::OP_FX1;
                            end
                        end
                        hmg_pkg::OP_FX1: op_next = hmg_pkg::OP_FZ1;
                        hmg_pkg::OP_FZ1:
                        begin
                            state_next = hmg_pkg::ST_RD_ADDR;
                            op_next    = hmg_pkg::OP_HLL;
                        end
                        hmg_pkg::OP_Q0: op_next = hmg_pkg::OP_Q1;
                        hmg_pkg::OP_Q1: op_next = hmg_pkg::OP_Q2;
                        default:        state_next = hmg_pkg::ST_EMIT;
                    endcase
                end
            end
            hmg_pkg::ST_RD_ADDR:
            begin
                state_next = hmg_pkg::ST_RD_DATA;
            end
            hmg_pkg::ST_RD_DATA:
            begin
                state_next = hmg_pkg::ST_RD_ADDR;
                case (op_reg)
                    hmg_pkg::OP_HLL:
                    begin
                        if (border)
                        begin
                            state_next = hmg_pkg::ST_EMIT;
                        end
                        else
                        begin
                            op_next = hmg_pkg::OP_HTL;
                        end
                    end
                    hmg_pkg::OP_HTL: op_next = hmg_pkg::OP_HTR;
                    hmg_pkg::OP_HTR: op_next = hmg_pkg::OP_HLR;
                    default:
                    begin
                        state_next = hmg_pkg::ST_MUL;
                        op_next    = hmg_pkg::OP_N0;
                    end
                endcase
            end
            hmg_pkg::ST_ABS:
            begin
                state_next = hmg_pkg::ST_SHIFT;
            end
            hmg_pkg::ST_SHIFT:
            begin
                if (!too_big)
                begin
                    state_next = hmg_pkg::ST_MUL;
                    op_next    = hmg_pkg::OP_S0;
                end
            end
            hmg_pkg::ST_ACC:
            begin
                state_next = hmg_pkg::ST_SQRT_GO;
            end
            hmg_pkg::ST_SQRT_GO:
            begin
                state_next = (sum_reg == '0) ? hmg_pkg::ST_EMIT : hmg_pkg::ST_SQRT_WAIT;
            end
            hmg_pkg::ST_SQRT_WAIT:
            begin
                if (sqrt_done)
                begin
                    state_next = hmg_pkg::ST_DIV_GO;
                    op_next    = hmg_pkg::OP_Q0;
                end
            end
            hmg_pkg::ST_WRITE:
            begin
                state_next = hmg_pkg::ST_IDLE;
            end
            hmg_pkg::ST_EMIT:
            begin
                if (out_load && emit_reg == hmg_pkg::V_LR)
                begin
                    state_next = hmg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hmg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall   = state_reg != hmg_pkg::ST_IDLE;
        div_start  = state_reg == hmg_pkg::ST_DIV_GO;
        sqrt_start = (state_reg == hmg_pkg::ST_SQRT_GO) && (sum_reg != '0);
        mem_we     = state_reg == hmg_pkg::ST_WRITE;
        out_load   = (state_reg == hmg_pkg::ST_EMIT) && (!out_valid_reg || !out_stall);
    end

    always_comb
    begin
        div_num   = '0;
        div_den   = hmg_pkg::DIV_DEN_W'(cols_reg);
        div_steps = hmg_pkg::FRAC_STEPS;
        case (op_reg)
            hmg_pkg::OP_LOAD:
            begin
                div_num   = hmg_pkg::DIV_NUM_W'({rg_reg, 8'd0});
                div_den   = hmg_pkg::DIV_DEN_W'({blue_reg, 8'd0} - {8'd0, blue_reg});
                div_steps = hmg_pkg::LOAD_STEPS;
            end
            hmg_pkg::OP_ROW:
            begin
                div_num   = hmg_pkg::DIV_NUM_W'(idx_reg);
                div_steps = hmg_pkg::ROW_STEPS;
            end
            hmg_pkg::OP_FX0: div_num = hmg_pkg::DIV_NUM_W'({col_reg, 16'd0});
            hmg_pkg::OP_FX1:
                div_num = hmg_pkg::DIV_NUM_W'({{1'b0, col_reg} + 8'd1, 16'd0});
            hmg_pkg::OP_FZ0:
            begin
                div_num = hmg_pkg::DIV_NUM_W'({row_reg[DW-1:0], 16'd0});
                div_den = hmg_pkg::DIV_DEN_W'(rows_reg);
            end
            hmg_pkg::OP_FZ1:
            begin
                div_num = hmg_pkg::DIV_NUM_W'({{1'b0, row_reg[DW-1:0]} + 8'd1, 16'd0});
                div_den = hmg_pkg::DIV_DEN_W'(rows_reg);
            end
            hmg_pkg::OP_Q0:
            begin
                div_num   = {mag_reg[0][29:0], 14'd0};
                div_den   = sqrt_root;
                div_steps = hmg_pkg::NRM_STEPS;
            end
            hmg_pkg::OP_Q1:
            begin
                div_num   = {mag_reg[1][29:0], 14'd0};
                div_den   = sqrt_root;
                div_steps = hmg_pkg::NRM_STEPS;
            end
            hmg_pkg::OP_Q2:
            begin
                div_num   = {mag_reg[2][29:0], 14'd0};
                div_den   = sqrt_root;
                div_steps = hmg_pkg::NRM_STEPS;
            end
            default:
            begin
                div_num = '0;
            end
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op_reg)
            hmg_pkg::OP_RG:
            begin
                mul_a = 32'({1'b0, red_reg});
                mul_b = 32'({1'b0, green_reg});
            end
            hmg_pkg::OP_N0:
            begin
                mul_a = 32'(az_reg);
                mul_b = 32'(dab_reg);
            end
            hmg_pkg::OP_N1:
            begin
                mul_a = 32'(az_reg);
                mul_b = 32'(bx_reg);
            end
            hmg_pkg::OP_N2:
            begin
                mul_a = 32'(nay_reg);
                mul_b = 32'(bx_reg);
            end
            hmg_pkg::OP_S0:
            begin
                mul_a = 32'({2'b00, mag_reg[0][29:0]});
                mul_b = 32'({2'b00, mag_reg[0][29:0]});
            end
            hmg_pkg::OP_S1:
            begin
                mul_a = 32'({2'b00, mag_reg[1][29:0]});
                mul_b = 32'({2'b00, mag_reg[1][29:0]});
            end
            hmg_pkg::OP_S2:
            begin
                mul_a = 32'({2'b00, mag_reg[2][29:0]});
                mul_b = 32'({2'b00, mag_reg[2][29:0]});
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_comb
    begin
        case (op_reg)
            hmg_pkg::OP_HTL: rd_addr = hmg_pkg::ADDR_W'(idx_reg) + hmg_pkg::ADDR_W'(cols_reg);
            hmg_pkg::OP_HTR:
                rd_addr = hmg_pkg::ADDR_W'(idx_reg) + hmg_pkg::ADDR_W'(cols_reg) +
                          hmg_pkg::ADDR_W'(1);
            hmg_pkg::OP_HLR: rd_addr = hmg_pkg::ADDR_W'(idx_reg) + hmg_pkg::ADDR_W'(1);
            default:         rd_addr = hmg_pkg::ADDR_W'(idx_reg);
        endcase
    end

    assign hdiff = (op_reg == hmg_pkg::OP_HTL)
                 ? $signed({1'b0, hll_reg}) - $signed({1'b0, rd_data})
                 : $signed({1'b0, htl_reg}) - $signed({1'b0, rd_data});

    always_comb
    begin
        out_next        = '0;
        out_next.norm_x = q_reg[0];
        out_next.norm_y = q_reg[1];
        out_next.norm_z = q_reg[2];
        out_next.last   = emit_reg == hmg_pkg::V_LR;
        out_next.pos_x  = fx0_reg;
        out_next.pos_z  = fz0_reg;
        out_next.pos_height = hll_reg;
        if (!border)
        begin
            case (emit_reg)
                hmg_pkg::V_TL:
                begin
                    out_next.pos_z      = fz1_reg;
                    out_next.pos_height = htl_reg;
                end
                hmg_pkg::V_TR0, hmg_pkg::V_TR1:
                begin
                    out_next.pos_x      = fx1_reg;
                    out_next.pos_z      = fz1_reg;
                    out_next.pos_height = htr_reg;
                end
                hmg_pkg::V_LR:
                begin
                    out_next.pos_x      = fx1_reg;
                    out_next.pos_height = hlr_reg;
                end
                default:
                begin
                    out_next.pos_x = fx0_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hmg_pkg::ST_IDLE;
            op_reg        <= hmg_pkg::OP_LOAD;
            emit_reg      <= hmg_pkg::V_LL0;
            cols_reg      <= hmg_pkg::DIM_RESET;
            rows_reg      <= hmg_pkg::DIM_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    hmg_pkg::REG_GRID_COLS: cols_reg <= clamp_dim(cfg_data);
                    hmg_pkg::REG_GRID_ROWS: rows_reg <= clamp_dim(cfg_data);
                    default:                cols_reg <= cols_reg;
                endcase
            end
            if (state_reg == hmg_pkg::ST_IDLE)
            begin
                emit_reg <= hmg_pkg::V_LL0;
            end
            else if (out_load)
            begin
                emit_reg <= hmg_pkg::vert_t'(3'(emit_reg) + 3'd1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == hmg_pkg::ST_IDLE && in_valid)
        begin
            idx_reg   <= in_data.item_index;
            red_reg   <= in_data.red;
            green_reg <= in_data.green;
            blue_reg  <= in_data.blue;
            hgt_reg   <= hmg_pkg::H_SAT;
            q_reg[0]  <= '0;
            q_reg[1]  <= '0;
            q_reg[2]  <= '0;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
        case (state_reg)
            hmg_pkg::ST_MUL:
            begin
                case (op_reg)
                    hmg_pkg::OP_RG: rg_reg <= mul_p[15:0];
                    hmg_pkg::OP_N0: n_reg[0] <= mul_p[NW-1:0];
                    hmg_pkg::OP_N1: n_reg[1] <= mul_p[NW-1:0];
                    hmg_pkg::OP_N2: n_reg[2] <= mul_p[NW-1:0];
                    hmg_pkg::OP_S0:
                    begin
                        sq_reg  <= mul_p[59:0];
                        sum_reg <= '0;
                    end
                    default:
                    begin
                        sq_reg  <= mul_p[59:0];
                        sum_reg <= sum_reg + {2'b00, sq_reg};
                    end
                endcase
            end
            hmg_pkg::ST_ACC:
            begin
                sum_reg <= sum_reg + {2'b00, sq_reg};
            end
            hmg_pkg::ST_ABS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sgn_reg[i] <= n_reg[i][NW-1];
                    mag_reg[i] <= n_reg[i][NW-1] ? MW'(-n_reg[i]) : MW'(n_reg[i]);
                end
            end
            hmg_pkg::ST_SHIFT:
            begin
                if (too_big)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end
            end
            hmg_pkg::ST_RD_DATA:
            begin
                case (op_reg)
                    hmg_pkg::OP_HLL: hll_reg <= rd_data;
                    hmg_pkg::OP_HTL:
                    begin
                        htl_reg <= rd_data;
                        nay_reg <= {hdiff, 8'd0};
                    end
                    hmg_pkg::OP_HTR:
                    begin
                        htr_reg <= rd_data;
                        dab_reg <= {hdiff, 8'd0};
                    end
                    default: hlr_reg <= rd_data;
                endcase
            end
            hmg_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    case (op_reg)
                        hmg_pkg::OP_LOAD: hgt_reg <= div_quot[15:0];
                        hmg_pkg::OP_ROW:
                        begin
                            row_reg <= div_quot[hmg_pkg::IDX_W-1:0];
                            col_reg <= div_rem[DW-1:0];
                        end
                        hmg_pkg::OP_FX0: fx0_reg <= div_quot[15:0];
                        hmg_pkg::OP_FZ0: fz0_reg <= div_quot[15:0];
                        hmg_pkg::OP_FX1:
                        begin
                            fx1_reg <= div_quot[15:0];
                            bx_reg  <= $signed({1'b0, div_quot[15:0]}) - $signed({1'b0, fx0_reg});
                        end
                        hmg_pkg::OP_FZ1:
                        begin
                            fz1_reg <= div_quot[15:0];
                            az_reg  <= $signed({1'b0, div_quot[15:0]}) - $signed({1'b0, fz0_reg});
                        end
                        hmg_pkg::OP_Q0: q_reg[0] <= sgn_reg[0] ? 16'(16'd0 - qmag) : qmag;
                        hmg_pkg::OP_Q1: q_reg[1] <= sgn_reg[1] ? 16'(16'd0 - qmag) : qmag;
                        default:        q_reg[2] <= sgn_reg[2] ? 16'(16'd0 - qmag) : qmag;
                    endcase
                end
            end
            default:
            begin
                sum_reg <= sum_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- design/hmg_div.sv -----
// ----------------------------------------------------------------------------
// Heightmap mesh generator divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hmg_div #(
    parameter int NUM_W = hmg_pkg::DIV_NUM_W,
    parameter int DEN_W = hmg_pkg::DIV_DEN_W,
    parameter int CNT_W = hmg_pkg::DIV_CNT_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [CNT_W-1:0] steps,
    output logic             done,
    output logic [NUM_W-1:0] quot,
    output logic [DEN_W-1:0] rem
);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= num << (CNT_W'(NUM_W) - steps);
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= num_reg << 1;
            quot_reg <= {quot_reg[NUM_W-2:0], fits};
            rem_reg  <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// ----- design/hmg_sqrt.sv -----
// ----------------------------------------------------------------------------
// Heightmap mesh generator square root
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module hmg_sqrt #(
    parameter int VAL_W  = hmg_pkg::SQ_VAL_W,
    parameter int ROOT_W = hmg_pkg::SQ_ROOT_W,
    parameter int CNT_W  = hmg_pkg::SQ_CNT_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [VAL_W-1:0]  value,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic [VAL_W-1:0]  val_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [ROOT_W+3:0] rem_t;
    logic [ROOT_W+3:0] trial;
    logic              fits;

    assign rem_t = {rem_reg, val_reg[VAL_W-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign fits  = rem_t >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg  <= val_reg << 2;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
            rem_reg  <= fits ? (ROOT_W+2)'(rem_t - trial) : rem_t[ROOT_W+1:0];
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- design/hmg_store.sv -----
// ----------------------------------------------------------------------------
// Heightmap mesh generator height store
// Single-port-write, registered-read memory of vertex heights.
// ----------------------------------------------------------------------------
module hmg_store #(
    parameter int DEPTH = hmg_pkg::DEF_MAX_VERTS
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [hmg_pkg::ADDR_W-1:0] waddr,
    input  logic [hmg_pkg::H_W-1:0]    wdata,
    input  logic [hmg_pkg::ADDR_W-1:0] raddr,
    output logic [hmg_pkg::H_W-1:0]    rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW = (AW > hmg_pkg::ADDR_W) ? AW : hmg_pkg::ADDR_W;

    logic [hmg_pkg::H_W-1:0] mem [DEPTH];
    logic [hmg_pkg::H_W-1:0] q_reg;
    logic                    oob_reg;
    logic [XW-1:0]           wext;
    logic [XW-1:0]           rext;
    logic                    win;
    logic                    rin;

    assign wext = XW'(waddr);
    assign rext = XW'(raddr);
    assign win  = 32'(waddr) < DEPTH;
    assign rin  = 32'(raddr) < DEPTH;

    always_ff @(posedge clk)
    begin
        if (we && win)
        begin
            mem[wext[AW-1:0]] <= wdata;
        end
        q_reg   <= mem[rext[AW-1:0]];
        oob_reg <= !rin;
    end

    assign rdata = oob_reg ? '0 : q_reg;

endmodule

// ----- design/hmg_checker.sv -----
// ----------------------------------------------------------------------------
// Heightmap mesh generator checker
// Port-level assertions for the heightmap mesh generator, bound to the top.
// ----------------------------------------------------------------------------
module hmg_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input hmg_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_stall,
    input hmg_pkg::out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("Output valid dropped while stalled.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("Output payload changed while stalled.");

    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Block took no time after an input transfer.");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.req_type == hmg_pkg::REQ_LOAD && !out_valid
        |=> !out_valid)
        else $error("A load produced an output.");

    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_stall |-> out_data.last)
        else $error("Block went idle in the middle of a cell.");

endmodule

bind heightmap_mesh_generator_unit hmg_checker u_hmg_checker (.*);
